/* rtl/ise_pkg.sv */
`default_nettype none
package ise_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int ACTION_W      = 4;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 7;
    localparam int OUT_TDATA_W   = 48;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_SUB    = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_SWAP   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_DUP    = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

    typedef logic [DATA_W-1:0] word_t;

endpackage
`default_nettype wire

/* rtl/integer_stack_engine_top.sv */
// LIFO stack of signed 32-bit words held in one synchronous memory (one write and
// one registered read port). Each transfer on the slave side carries an action in
// s_tuser and an operand in s_tdata and yields exactly one result transfer on the
// master side. Push, clear, unused codes and refused actions go from the input
// transfer straight to the result state; pop, peek, add, subtract and duplicate
// first make one memory read of the top; swap makes two reads and two writes
// through the single write port; search walks the held entries one memory read
// per cycle. The next item is accepted in the cycle after the previous one has
// reached the output register, even if that result has not yet been taken. No
// clearing pass is needed after reset.
`default_nettype none
module integer_stack_engine_top
    import ise_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [DATA_W-1:0]      s_tdata,   // [31:0] operand
    input  wire logic [ACTION_W-1:0]    s_tuser,   // [3:0] action
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [31:0] read_value, [32] found, [33] is_empty, [40:34] fill_count,
    // [42:41] status, [47:43] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_READ2  = 3'd2;
    localparam logic [2:0] S_SWAPW  = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    logic [2:0]          state_reg, state_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    word_t               opnd_reg, opnd_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       scan_reg, scan_next;
    word_t               tmp_reg, tmp_next;
    word_t               rd_reg, rd_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          we;
    logic [AW-1:0] wa;
    word_t         wd;
    logic [AW-1:0] ra;

    logic [CW-1:0] cnt_m1, cnt_m2;
    logic [AW-1:0] top_addr, sec_addr;
    logic [CW+FILL_W-1:0] fill_ext;
    logic          s_xfer;
    logic          out_free;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign top_addr = cnt_m1[AW-1:0];
    assign sec_addr = cnt_m2[AW-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fill_ext = {{FILL_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        opnd_next     = opnd_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        tmp_next      = tmp_reg;
        rd_next       = rd_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        we            = 1'b0;
        wa            = top_addr;
        wd            = rd_data_reg;
        ra            = top_addr;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    act_next    = s_tuser;
                    opnd_next   = s_tdata;
                    rd_next     = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (s_tuser)
                        ACT_PUSH:
                        begin
                            if (count_reg == DEPTH_CNT)
                            begin
                                status_next = ST_OVER;
                            end
                            else
                            begin
                                we         = 1'b1;
                                wa         = count_reg[AW-1:0];
                                wd         = s_tdata;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_POP, ACT_PEEK, ACT_ADD, ACT_SUB:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        ACT_DUP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNDER;
                            end
                            else if (count_reg == DEPTH_CNT)
                            begin
                                status_next = ST_OVER;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        ACT_SWAP:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                ra         = '0;
                                scan_next  = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_POP:
                    begin
                        rd_next    = rd_data_reg;
                        count_next = cnt_m1;
                    end
                    ACT_PEEK:
                    begin
                        rd_next = rd_data_reg;
                    end
                    ACT_ADD:
                    begin
                        we = 1'b1;
                        wd = rd_data_reg + opnd_reg;
                    end
                    ACT_SUB:
                    begin
                        we = 1'b1;
                        wd = rd_data_reg - opnd_reg;
                    end
                    ACT_DUP:
                    begin
                        we         = 1'b1;
                        wa         = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                    ACT_SWAP:
                    begin
                        tmp_next   = rd_data_reg;
                        ra         = sec_addr;
                        state_next = S_READ2;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_READ2:
            begin
                // second entry lands on top
                we         = 1'b1;
                state_next = S_SWAPW;
            end
            S_SWAPW:
            begin
                we         = 1'b1;
                wa         = sec_addr;
                wd         = tmp_reg;
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                if (rd_data_reg == opnd_reg)
                begin
                    found_next = 1'b1;
                end
                if (scan_reg == top_addr)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                    ra        = scan_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, status_reg, fill_ext[FILL_W-1:0],
                                     (count_reg == '0), found_reg, rd_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        opnd_reg    <= opnd_next;
        scan_reg    <= scan_next;
        tmp_reg     <= tmp_next;
        rd_reg      <= rd_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

/* rtl/ise_checker.sv */
`default_nettype none
module ise_checker
    import ise_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] out_status;

    assign out_status = m_tdata[42:41];

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_status == ST_OK || out_status == ST_OVER ||
                      out_status == ST_UNDER))
        else $error("undefined status code");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> (m_tdata[31:0] == '0) && (out_status == ST_OK))
        else $error("found set on a non-search result");

    a_over_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status == ST_OVER |-> !m_tdata[33])
        else $error("overflow reported on an empty stack");

    a_under_zero_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status == ST_UNDER |-> (m_tdata[31:0] == '0))
        else $error("refused read returned data");

endmodule

bind integer_stack_engine_top ise_checker u_ise_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
